// ----- src/cscan_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cscan_pkg;

   localparam int MAX_REQUESTS = 32;
   localparam int ADDR_W = $clog2(MAX_REQUESTS);
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam int CYL_W = 10;
   localparam int MOVE_W = 16;
   localparam logic [CYL_W-1:0] MAX_CYL_RESET = CYL_W'(199);

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_RUN = 1'b1;
   localparam logic DIR_UP = 1'b1;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [CYL_W-1:0]  wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_cmd_type;

   typedef struct packed {
      logic             gt;
      logic [CYL_W-1:0] diff;
   } alu_res_type;

endpackage

`default_nettype wire

// ----- src/cscan_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sorted request store: one write port, one registered read port.
module cscan_store (
   input  wire logic                      clock,
   input  wire cscan_pkg::mem_cmd_type    cmd,
   output logic [cscan_pkg::CYL_W-1:0]    rdata
);

   logic [cscan_pkg::CYL_W-1:0] mem [cscan_pkg::MAX_REQUESTS];
   logic [cscan_pkg::CYL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr] <= cmd.wdata;
      end
      rdata_ff <= mem[cmd.raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- src/cscan_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shared compare / absolute-difference unit.
module cscan_alu (
   input  wire logic [cscan_pkg::CYL_W-1:0] a,
   input  wire logic [cscan_pkg::CYL_W-1:0] b,
   output cscan_pkg::alu_res_type           res
);

   always_comb begin
      res.gt = (a > b);
      res.diff = (a > b) ? (a - b) : (b - a);
   end

endmodule

`default_nettype wire

// ----- src/c_scan_disk_scheduler_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Load request: each larger entry is read, compared and shifted up one slot by the sorted
// insert until the new entry is written. Run with an empty store: one empty result is given.
// Run request: scan for the split point, a read and a compare per entry examined, one setup
// step, then fetch, move and output per result; output waits while rsp_stall holds a result.
// One request is worked at a time; req_stall is high until the sequencer returns to idle.
// Sync active-high reset: count 0, max cylinder 199, no result pending; store not cleared.
module c_scan_disk_scheduler_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_mode,
   input  wire logic [cscan_pkg::CYL_W-1:0]   req_request_cylinder,
   input  wire logic [cscan_pkg::CYL_W-1:0]   req_start_position,
   input  wire logic                          req_direction,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [cscan_pkg::CYL_W-1:0]        rsp_position,
   output logic                               rsp_is_sweep_end,
   output logic [cscan_pkg::MOVE_W-1:0]       rsp_total_movement,
   output logic                               rsp_last,
   output logic                               rsp_empty_res,
   input  wire logic                          csr_wr_en,
   input  wire logic [cscan_pkg::CYL_W-1:0]   csr_wr_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SETUP,
      ST_FETCH,
      ST_MOVE,
      ST_OUT,
      ST_EMPTY
   } state_type;

   typedef enum logic [1:0] {
      SEG_FIRST,
      SEG_EDGE_A,
      SEG_EDGE_B,
      SEG_SECOND
   } seg_type;

   state_type state_ff, state_in;
   seg_type   seg_ff, seg_in;

   logic [cscan_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [cscan_pkg::CNT_W-1:0]  n_ff, n_in;
   logic [cscan_pkg::CNT_W-1:0]  split_ff, split_in;
   logic [cscan_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [cscan_pkg::CYL_W-1:0]  key_ff, key_in;      // inserted value, then current head
   logic                         dir_ff, dir_in;
   logic [cscan_pkg::CYL_W-1:0]  pos_ff, pos_in;
   logic                         edge_ff, edge_in;
   logic [cscan_pkg::MOVE_W-1:0] total_ff, total_in;
   logic [cscan_pkg::CYL_W-1:0]  max_cyl_ff, max_cyl_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cscan_pkg::CYL_W-1:0]  rsp_position_ff, rsp_position_in;
   logic                         rsp_sweep_ff, rsp_sweep_in;
   logic [cscan_pkg::MOVE_W-1:0] rsp_total_ff, rsp_total_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_empty_ff, rsp_empty_in;

   cscan_pkg::mem_cmd_type       mem_cmd;
   logic [cscan_pkg::CYL_W-1:0]  mem_rdata;
   logic [cscan_pkg::CYL_W-1:0]  alu_a, alu_b;
   cscan_pkg::alu_res_type       alu_res;

   logic [cscan_pkg::CNT_W-1:0]  seg1_first, seg1_last, seg2_first, seg2_last;
   logic                         seg1_ok, edges_ok;
   logic                         out_free, is_last;
   logic [cscan_pkg::CNT_W-1:0]  idx_step;
   logic [cscan_pkg::CYL_W-1:0]  pos_val;
   logic [cscan_pkg::MOVE_W:0]   move_sum;

   cscan_store u_store (
      .clock (clock),
      .cmd   (mem_cmd),
      .rdata (mem_rdata)
   );

   cscan_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   // Segment bounds; both segments walk in the sweep direction.
   always_comb begin
      if (dir_ff == cscan_pkg::DIR_UP) begin
         seg1_first = split_ff;
         seg1_last  = n_ff - 1'b1;
         seg1_ok    = (split_ff != n_ff);
         seg2_first = '0;
         seg2_last  = split_ff - 1'b1;
         edges_ok   = (split_ff != '0);
         idx_step   = idx_ff + 1'b1;
      end else begin
         seg1_first = split_ff - 1'b1;
         seg1_last  = '0;
         seg1_ok    = (split_ff != '0);
         seg2_first = n_ff - 1'b1;
         seg2_last  = split_ff;
         edges_ok   = (split_ff != n_ff);
         idx_step   = idx_ff - 1'b1;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_last  = ((seg_ff == SEG_FIRST) && (idx_ff == seg1_last) && !edges_ok)
                     || ((seg_ff == SEG_SECOND) && (idx_ff == seg2_last));
   assign pos_val  = edge_ff ? pos_ff : mem_rdata;
   assign move_sum = {1'b0, total_ff} + (cscan_pkg::MOVE_W + 1)'(alu_res.diff);

   always_comb begin
      state_in        = state_ff;
      seg_in          = seg_ff;
      count_in        = count_ff;
      n_in            = n_ff;
      split_in        = split_ff;
      idx_in          = idx_ff;
      key_in          = key_ff;
      dir_in          = dir_ff;
      pos_in          = pos_ff;
      edge_in         = edge_ff;
      total_in        = total_ff;
      max_cyl_in      = csr_wr_en ? csr_wr_data : max_cyl_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_position_in = rsp_position_ff;
      rsp_sweep_in    = rsp_sweep_ff;
      rsp_total_in    = rsp_total_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_empty_in    = rsp_empty_ff;

      mem_cmd.we    = 1'b0;
      mem_cmd.waddr = idx_ff[cscan_pkg::ADDR_W-1:0];
      mem_cmd.wdata = key_ff;
      mem_cmd.raddr = idx_ff[cscan_pkg::ADDR_W-1:0];
      alu_a         = mem_rdata;
      alu_b         = key_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_mode == cscan_pkg::MODE_LOAD) begin
                  if (count_ff != cscan_pkg::CNT_W'(cscan_pkg::MAX_REQUESTS)) begin
                     key_in   = req_request_cylinder;
                     idx_in   = count_ff;
                     count_in = count_ff + 1'b1;
                     state_in = ST_INS_RD;
                  end
               end else begin
                  n_in     = count_ff;
                  count_in = '0;
                  key_in   = req_start_position;
                  dir_in   = req_direction;
                  idx_in   = '0;
                  split_in = '0;
                  total_in = '0;
                  state_in = (count_ff == '0) ? ST_EMPTY : ST_SCAN_RD;
               end
            end
         end
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               mem_cmd.we = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               mem_cmd.raddr = cscan_pkg::ADDR_W'(idx_ff - 1'b1);
               state_in      = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            mem_cmd.we = 1'b1;
            if (alu_res.gt) begin
               // shift the larger entry up one slot
               mem_cmd.wdata = mem_rdata;
               idx_in        = idx_ff - 1'b1;
               state_in      = ST_INS_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (!alu_res.gt) begin
               split_in = split_ff + 1'b1;
            end
            if (alu_res.gt || (idx_ff == n_ff - 1'b1)) begin
               state_in = ST_SETUP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SETUP: begin
            if (seg1_ok) begin
               seg_in = SEG_FIRST;
               idx_in = seg1_first;
            end else begin
               seg_in = SEG_EDGE_A;
            end
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            case (seg_ff)
               SEG_EDGE_A: begin
                  pos_in  = (dir_ff == cscan_pkg::DIR_UP) ? max_cyl_ff : '0;
                  edge_in = 1'b1;
               end
               SEG_EDGE_B: begin
                  pos_in  = (dir_ff == cscan_pkg::DIR_UP) ? '0 : max_cyl_ff;
                  edge_in = 1'b1;
               end
               default: begin
                  edge_in = 1'b0;
               end
            endcase
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            alu_a    = key_ff;
            alu_b    = pos_val;
            total_in = move_sum[cscan_pkg::MOVE_W] ? '1 : move_sum[cscan_pkg::MOVE_W-1:0];
            key_in   = pos_val;
            pos_in   = pos_val;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = pos_ff;
               rsp_sweep_in    = edge_ff;
               rsp_total_in    = is_last ? total_ff : '0;
               rsp_last_in     = is_last;
               rsp_empty_in    = 1'b0;
               state_in        = ST_FETCH;
               case (seg_ff)
                  SEG_FIRST: begin
                     if (idx_ff == seg1_last) begin
                        if (edges_ok) begin
                           seg_in = SEG_EDGE_A;
                        end else begin
                           state_in = ST_IDLE;
                        end
                     end else begin
                        idx_in = idx_step;
                     end
                  end
                  SEG_EDGE_A: begin
                     seg_in = SEG_EDGE_B;
                  end
                  SEG_EDGE_B: begin
                     seg_in = SEG_SECOND;
                     idx_in = seg2_first;
                  end
                  default: begin
                     if (idx_ff == seg2_last) begin
                        state_in = ST_IDLE;
                     end else begin
                        idx_in = idx_step;
                     end
                  end
               endcase
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = '0;
               rsp_sweep_in    = 1'b0;
               rsp_total_in    = '0;
               rsp_last_in     = 1'b1;
               rsp_empty_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seg_ff       <= SEG_FIRST;
         count_ff     <= '0;
         max_cyl_ff   <= cscan_pkg::MAX_CYL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         count_ff     <= count_in;
         max_cyl_ff   <= max_cyl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff            <= n_in;
      split_ff        <= split_in;
      idx_ff          <= idx_in;
      key_ff          <= key_in;
      dir_ff          <= dir_in;
      pos_ff          <= pos_in;
      edge_ff         <= edge_in;
      total_ff        <= total_in;
      rsp_position_ff <= rsp_position_in;
      rsp_sweep_ff    <= rsp_sweep_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_empty_ff    <= rsp_empty_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position       = rsp_position_ff;
   assign rsp_is_sweep_end   = rsp_sweep_ff;
   assign rsp_total_movement = rsp_total_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_empty_res      = rsp_empty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cscan_pkg::CNT_W'(cscan_pkg::MAX_REQUESTS))
      else $error("request count above capacity");

   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode == cscan_pkg::MODE_RUN) |=> count_ff == '0)
      else $error("run did not clear the store");

   a_total_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_total_movement == '0)
      else $error("movement shown before last result");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last && (rsp_position == '0) && !rsp_is_sweep_end)
      else $error("malformed empty result");

endmodule

`default_nettype wire
